### hdl/tlsa_pkg.sv
// ----------------------------------------------------------------------------
// tlsa_pkg: shared types and constants for the tile layer scroll address core
// Register indexes, screen limits, and the item, result and config bundles.
// ----------------------------------------------------------------------------
package tlsa_pkg;

  localparam int unsigned ScreenWidth  = 496;
  localparam int unsigned ScreenHeight = 384;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 24;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_A_HSCROLL  = 3'd0,
    CFG_A_VSCROLL  = 3'd1,
    CFG_B_HSCROLL  = 3'd2,
    CFG_B_VSCROLL  = 3'd3,
    CFG_WINDOW_EN  = 3'd4
  } cfg_idx_t;

  // Bit positions inside a 16-bit scroll or control word
  localparam int unsigned BitLineSel = 15;
  localparam int unsigned BitOff     = 15;
  localparam int unsigned BitWide    = 14;
  localparam int unsigned BitTall    = 13;
  localparam int unsigned BitSingle  = 15;

  typedef struct packed {
    logic [31:0] a_hscroll;
    logic [31:0] a_vscroll;
    logic [31:0] b_hscroll;
    logic [31:0] b_vscroll;
    logic        window_en;
  } tlsa_cfg_t;

  typedef struct packed {
    logic        layer_select;
    logic [8:0]  line_number;
    logic [8:0]  pixel_x;
    logic [15:0] primary_line_scroll;
    logic [15:0] secondary_line_scroll;
    logic        window_bit;
  } item_t;

  typedef struct packed {
    logic       blank;
    logic [1:0] map_select;
    logic [8:0] source_row;
    logic [8:0] source_column;
  } result_t;

endpackage

### hdl/tile_layer_scroll_address_core.sv
// ----------------------------------------------------------------------------
// tile_layer_scroll_address_core: tile layer pixel source address generator
// Picks the map (0..3) and the row and column within it for one pixel of
// layer A or B from the scroll and control registers.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   in_     | in  | tvalid / tready    | tdata pixel fields, tuser layer
//   out_    | out | tvalid / tready    | tdata map/row/column, tuser blank
//   cfg_    | in  | valid / ready      | index, 32-bit data
//
// One beat per clock sustained while out_tready stays high; an accepted beat
// passes the input register, then the result register, before out_tvalid
// rises and the output handshake can follow.
// in_tready drops only while the input register is full and the result
// register is held by out_tready low.
// cfg_ready is always high; a write is registered straight into the config register.
// rst_n is synchronous: valids clear and the config registers take their reset values.
// ----------------------------------------------------------------------------
module tile_layer_scroll_address_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // line_number[8:0], pixel_x[17:9], primary_line_scroll[33:18],
  // secondary_line_scroll[49:34], window_bit[50], zero[55:51]
  input  logic [tlsa_pkg::InDataW-1:0]    in_tdata,
  // layer_select[0]
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // map_select[1:0], source_row[10:2], source_column[19:11], zero[23:20]
  output logic [tlsa_pkg::OutDataW-1:0]   out_tdata,
  // blank[0]
  output logic                            out_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlsa_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [31:0]                     cfg_data
);
  import tlsa_pkg::*;

  tlsa_cfg_t cfg_r;
  item_t     item_r;
  logic      item_valid_r;
  result_t   res_r;
  logic      out_valid_r;
  result_t   res_nxt;
  logic      out_adv;
  logic      item_adv;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{a_hscroll: 32'd0, a_vscroll: 32'd0, b_hscroll: 32'd0,
                 b_vscroll: 32'd0, window_en: 1'b1};
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_A_HSCROLL: cfg_r.a_hscroll <= cfg_data;
        CFG_A_VSCROLL: cfg_r.a_vscroll <= cfg_data;
        CFG_B_HSCROLL: cfg_r.b_hscroll <= cfg_data;
        CFG_B_VSCROLL: cfg_r.b_vscroll <= cfg_data;
        CFG_WINDOW_EN: cfg_r.window_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Result register frees when empty or taken this cycle
  assign out_adv   = ~out_valid_r | out_tready;
  assign item_adv  = item_valid_r & out_adv;
  assign in_tready = ~item_valid_r | out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.layer_select          <= in_tuser;
      item_r.line_number           <= in_tdata[8:0];
      item_r.pixel_x               <= in_tdata[17:9];
      item_r.primary_line_scroll   <= in_tdata[33:18];
      item_r.secondary_line_scroll <= in_tdata[49:34];
      item_r.window_bit            <= in_tdata[50];
    end
    if (item_adv) begin
      res_r <= res_nxt;
    end
  end

  tlsa_addr_calc u_calc (
    .cfg  (cfg_r),
    .item (item_r),
    .res  (res_nxt)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.blank;
  assign out_tdata  = {4'd0, res_r.source_column, res_r.source_row, res_r.map_select};

  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.blank |-> out_tdata == '0)
    else $error("blank result carries nonzero address");

  a_item_moves: assert property (@(posedge clk) disable iff (!rst_n)
    item_adv |=> out_valid_r)
    else $error("item advanced but result register empty");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty result register");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && !out_adv |=> item_valid_r && $stable(item_r))
    else $error("pending item lost during output stall");

endmodule

### hdl/tlsa_addr_calc.sv
// ----------------------------------------------------------------------------
// tlsa_addr_calc: map, row and column for one pixel
// Pure combinational path: scroll negation, row add, mode decode and the
// final map select. Sits between the input and result registers.
// ----------------------------------------------------------------------------
module tlsa_addr_calc (
  input  tlsa_pkg::tlsa_cfg_t cfg,
  input  tlsa_pkg::item_t     item,
  output tlsa_pkg::result_t   res
);
  import tlsa_pkg::*;

  logic [31:0] hs, vs;
  logic [15:0] pw, sw, vw, ww;
  logic        wide, tall, off, single, huge;
  logic [15:0] p_sel, s_sel;
  logic [9:0]  h1, r1, s_prim;
  logic [8:0]  h2, r2, s_sec;
  logic        off_screen;
  logic        use_prim, use_sec;

  always_comb begin
    hs = item.layer_select ? cfg.b_hscroll : cfg.a_hscroll;
    vs = item.layer_select ? cfg.b_vscroll : cfg.a_vscroll;
    pw = hs[15:0];
    sw = hs[31:16];
    vw = vs[15:0];
    ww = vs[31:16];

    wide   = vw[BitWide];
    tall   = vw[BitTall];
    off    = vw[BitOff];
    single = ww[BitSingle] | ~cfg.window_en;
    huge   = (cfg.a_vscroll[BitWide] & cfg.a_vscroll[BitTall]) |
             (cfg.b_vscroll[BitWide] & cfg.b_vscroll[BitTall]);

    p_sel = pw[BitLineSel] ? item.primary_line_scroll : pw;
    s_sel = sw[BitLineSel] ? item.secondary_line_scroll : sw;

    // Horizontal scroll runs negated; bit 9 only survives in wide mode
    h1 = 10'd0 - p_sel[9:0];
    if (!wide) begin
      h1[9] = 1'b0;
    end
    h2 = 9'd0 - s_sel[8:0];

    r1 = vw[9:0] + {1'b0, item.line_number};
    if (!tall) begin
      r1[9] = 1'b0;
    end
    r2 = ww[8:0] + item.line_number;

    s_prim = h1 + {1'b0, item.pixel_x};
    s_sec  = h2 + item.pixel_x;

    off_screen = ({1'b0, item.line_number} >= 10'(ScreenHeight)) ||
                 ({1'b0, item.pixel_x} >= 10'(ScreenWidth));

    res      = '0;
    use_prim = 1'b0;
    use_sec  = 1'b0;
    priority if (huge || off_screen) begin
      res.blank = 1'b1;
    end else if (!off && wide) begin
      res.map_select    = {item.layer_select, s_prim[9]};
      res.source_row    = r1[8:0];
      res.source_column = s_prim[8:0];
    end else if (single) begin
      res.blank = off;
      use_prim  = ~off;
    end else if (off || item.window_bit) begin
      use_sec = 1'b1;
    end else begin
      use_prim = 1'b1;
    end

    if (use_prim) begin
      // Tall plane: rows past 511 fall into the secondary map
      res.map_select    = {item.layer_select, r1[9]};
      res.source_row    = r1[8:0];
      res.source_column = s_prim[8:0];
    end else if (use_sec) begin
      res.map_select    = {item.layer_select, 1'b1};
      res.source_row    = r2;
      res.source_column = s_sec;
    end
  end

endmodule

### verif/tile_layer_scroll_address_core_tb.sv
// ----------------------------------------------------------------------------
// tile_layer_scroll_address_core_tb: self-checking bench for the scroll core
// Drives pixel beats under random gaps and output stalls. A local address
// predictor, kept in step with the register writes, queues the expected map,
// row and column of every accepted beat. Each output beat is checked in order.
// ----------------------------------------------------------------------------
module tile_layer_scroll_address_core_tb;
  import tlsa_pkg::*;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned HoldCycles = 300;
  localparam longint unsigned TimeoutTicks = 64'd20_000_000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  tlsa_cfg_t   shadow_cfg;
  result_t     pending_addr_q[$];
  int unsigned mismatch_count = 0;
  bit          src_steady = 1'b0;
  logic        rcv_steady = 1'b0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int unsigned hold_left = 0;

  tile_layer_scroll_address_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #(HalfPeriod) clk = ~clk;

  initial begin
    #(TimeoutTicks);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic result_t predict_source_addr(input item_t it);
    logic [31:0] hs, vs;
    logic [15:0] pw, sw, vw, ww, neg1, neg2;
    logic        wide, tall, off, single, huge;
    logic [1:0]  prim, sec;
    logic [9:0]  h1, r1, s1;
    logic [8:0]  h2, r2;
    logic        use_prim, use_sec;
    result_t     res;
    hs = it.layer_select ? shadow_cfg.b_hscroll : shadow_cfg.a_hscroll;
    vs = it.layer_select ? shadow_cfg.b_vscroll : shadow_cfg.a_vscroll;
    pw = hs[15:0];
    sw = hs[31:16];
    vw = vs[15:0];
    ww = vs[31:16];
    wide = vw[BitWide];
    tall = vw[BitTall];
    off = vw[BitOff];
    single = ww[BitSingle] || !shadow_cfg.window_en;
    huge = (shadow_cfg.a_vscroll[BitWide] && shadow_cfg.a_vscroll[BitTall]) ||
           (shadow_cfg.b_vscroll[BitWide] && shadow_cfg.b_vscroll[BitTall]);
    prim = {it.layer_select, 1'b0};
    sec = {it.layer_select, 1'b1};
    // scroll is negated; per-line input replaces the word when its bit 15 is set
    neg1 = 16'd0 - (pw[BitLineSel] ? it.primary_line_scroll : pw);
    neg2 = 16'd0 - (sw[BitLineSel] ? it.secondary_line_scroll : sw);
    h1 = wide ? neg1[9:0] : {1'b0, neg1[8:0]};
    h2 = neg2[8:0];
    r1 = vw[9:0] + {1'b0, it.line_number};
    if (!tall) r1[9] = 1'b0;
    r2 = ww[8:0] + it.line_number;
    s1 = h1 + {1'b0, it.pixel_x};
    res = '0;
    use_prim = 1'b0;
    use_sec = 1'b0;
    if (huge || it.line_number >= ScreenHeight || it.pixel_x >= ScreenWidth) begin
      res.blank = 1'b1;
    end else if (!off && wide) begin
      res.map_select = s1[9] ? sec : prim;
      res.source_column = s1[8:0];
      res.source_row = r1[8:0];
    end else if (single) begin
      if (off) res.blank = 1'b1;
      else use_prim = 1'b1;
    end else if (off || it.window_bit) begin
      use_sec = 1'b1;
    end else begin
      use_prim = 1'b1;
    end
    if (use_prim) begin
      res.map_select = r1[9] ? sec : prim;
      res.source_row = r1[8:0];
      res.source_column = s1[8:0];
    end else if (use_sec) begin
      res.map_select = sec;
      res.source_row = r2;
      res.source_column = h2 + it.pixel_x;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [8:0] exp_v,
                             input logic [8:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Output side: check each beat, then choose tready for the next edge
  always @(posedge clk) begin
    result_t exp_r;
    if (out_tvalid && out_tready) begin
      if (pending_addr_q.size() == 0) begin
        $display("%0t: unexpected output beat, actual blank %0b map %0d row %0d col %0d",
                 $time, out_tuser, out_tdata[1:0], out_tdata[10:2], out_tdata[19:11]);
        mismatch_count++;
      end else begin
        exp_r = pending_addr_q.pop_front();
        check_field("blank", {8'd0, exp_r.blank}, {8'd0, out_tuser});
        check_field("map_select", {7'd0, exp_r.map_select}, {7'd0, out_tdata[1:0]});
        check_field("source_row", exp_r.source_row, out_tdata[10:2]);
        check_field("source_column", exp_r.source_column, out_tdata[19:11]);
      end
    end
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (rcv_steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 25);
    end
  end

  function automatic item_t make_pixel(input logic layer, input logic [8:0] line,
                                       input logic [8:0] px, input logic [15:0] pls,
                                       input logic [15:0] sls, input logic wbit);
    item_t it;
    it.layer_select = layer;
    it.line_number = line;
    it.pixel_x = px;
    it.primary_line_scroll = pls;
    it.secondary_line_scroll = sls;
    it.window_bit = wbit;
    return it;
  endfunction

  function automatic item_t rand_pixel();
    item_t it;
    it.layer_select = 1'($urandom_range(1));
    it.line_number = ($urandom_range(9) == 0) ? 9'($urandom_range(511, ScreenHeight))
                                               : 9'($urandom_range(ScreenHeight - 1));
    it.pixel_x = ($urandom_range(9) == 0) ? 9'($urandom_range(511, ScreenWidth))
                                           : 9'($urandom_range(ScreenWidth - 1));
    it.primary_line_scroll = 16'($urandom);
    it.secondary_line_scroll = 16'($urandom);
    it.window_bit = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic logic [31:0] rand_vscroll();
    logic [31:0] v;
    v = $urandom;
    // keep 1024x1024 mode rare, it blanks both layers
    if (v[BitWide] && v[BitTall] && $urandom_range(7) != 0) v[BitTall] = 1'b0;
    return v;
  endfunction

  // Leaves in_tvalid high at the acceptance edge; the next call or a drain lowers it
  task automatic send_pixel(input item_t it);
    if (!src_steady) begin
      while ($urandom_range(99) < 25) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser <= it.layer_select;
    in_tdata <= {5'd0, it.window_bit, it.secondary_line_scroll, it.primary_line_scroll,
                 it.pixel_x, it.line_number};
    do @(posedge clk); while (!in_tready);
    pending_addr_q.push_back(predict_source_addr(it));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_addr_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_A_HSCROLL: shadow_cfg.a_hscroll = val;
      CFG_A_VSCROLL: shadow_cfg.a_vscroll = val;
      CFG_B_HSCROLL: shadow_cfg.b_hscroll = val;
      CFG_B_VSCROLL: shadow_cfg.b_vscroll = val;
      CFG_WINDOW_EN: shadow_cfg.window_en = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_config(input logic [31:0] ah, input logic [31:0] av,
                             input logic [31:0] bh, input logic [31:0] bv,
                             input logic [31:0] we);
    wait_drained();
    write_reg(CFG_A_HSCROLL, ah);
    write_reg(CFG_A_VSCROLL, av);
    write_reg(CFG_B_HSCROLL, bh);
    write_reg(CFG_B_VSCROLL, bv);
    write_reg(CFG_WINDOW_EN, we);
  endtask

  task automatic test_reset_state();
    send_pixel(make_pixel(1'b0, 9'd0, 9'd0, 16'h0000, 16'h0000, 1'b0));
    send_pixel(make_pixel(1'b1, 9'd383, 9'd495, 16'hffff, 16'hffff, 1'b1));
  endtask

  task automatic test_directed_cases();
    // wide plane: column sum crossing 512 moves to the secondary map
    load_config(32'h0010_0123, 32'h0000_4005, 32'h0, 32'h0, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd7, 9'd0, 16'h0, 16'h0, 1'b1));
    send_pixel(make_pixel(1'b0, 9'd7, 9'd300, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(1'b0, 9'd7, 9'd495, 16'h0, 16'h0, 1'b1));
    // wide with primary off falls through to the secondary
    load_config(32'h0010_0123, 32'h0020_c000, 32'h0, 32'h0, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd100, 9'd50, 16'h0, 16'h0, 1'b0));
    // single with primary off is blank; single with primary on ignores window
    load_config(32'h0, 32'h8000_8000, 32'h0, 32'h8000_0010, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd20, 9'd20, 16'h0, 16'h0, 1'b1));
    send_pixel(make_pixel(1'b1, 9'd20, 9'd20, 16'h0, 16'h0, 1'b1));
    // tall plane: rows past 511 read the secondary map
    load_config(32'h0, 32'h0000_2100, 32'h0, 32'h0, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd300, 9'd9, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(1'b0, 9'd10, 9'd9, 16'h0, 16'h0, 1'b0));
    // per-line scroll on both words
    load_config(32'h8000_8000, 32'h0, 32'h8000_8000, 32'h0003_0002, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd5, 9'd1, 16'hffff, 16'h0001, 1'b0));
    send_pixel(make_pixel(1'b1, 9'd5, 9'd1, 16'h0000, 16'hffff, 1'b1));
    // 1024x1024 on layer B blanks layer A as well
    load_config(32'h0, 32'h0, 32'h0, 32'h0000_6000, 32'h1);
    send_pixel(make_pixel(1'b0, 9'd1, 9'd1, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(1'b1, 9'd1, 9'd1, 16'h0, 16'h0, 1'b1));
    // off screen in either direction, window disabled forces the primary
    load_config(32'h0005_0004, 32'h0007_0006, 32'h0, 32'h0, 32'h0);
    send_pixel(make_pixel(1'b0, 9'd384, 9'd0, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(1'b0, 9'd511, 9'd0, 16'h0, 16'h0, 1'b1));
    send_pixel(make_pixel(1'b1, 9'd0, 9'd496, 16'h0, 16'h0, 1'b0));
    send_pixel(make_pixel(1'b1, 9'd0, 9'd511, 16'h0, 16'h0, 1'b1));
    send_pixel(make_pixel(1'b0, 9'd40, 9'd40, 16'h0, 16'h0, 1'b1));
  endtask

  task automatic test_random_phases();
    int unsigned phase;
    for (phase = 0; phase < 10; phase++) begin
      case (phase)
        0: load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        1: load_config(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                       32'hffff_ffff);
        2: load_config(32'h01ff_03ff, 32'h01ff_43ff, 32'h01ff_03ff, 32'h01ff_23ff, 32'h1);
        default: load_config($urandom, rand_vscroll(), $urandom, rand_vscroll(),
                             32'($urandom_range(3) != 0));
      endcase
      // one phase runs with no idling on either side
      src_steady = (phase == 4);
      rcv_steady <= (phase == 4);
      repeat (45) send_pixel(rand_pixel());
    end
    src_steady = 1'b0;
    rcv_steady <= 1'b0;
  endtask

  task automatic test_output_stall();
    load_config($urandom, rand_vscroll(), $urandom, rand_vscroll(), 32'h1);
    // hold the output off while beats keep coming, so the input stalls
    hold_toggle <= ~hold_toggle;
    src_steady = 1'b1;
    repeat (40) send_pixel(rand_pixel());
    src_steady = 1'b0;
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.window_en = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_directed_cases();
    test_random_phases();
    test_output_stall();
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_addr_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
hdl/tlsa_pkg.sv
hdl/tlsa_addr_calc.sv
hdl/tile_layer_scroll_address_core.sv
verif/tile_layer_scroll_address_core_tb.sv
